@@ src/kct_pkg.sv @@
// Shared types, codes and segment table for the keypad countdown timer.
package kct_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int HOLD_W         = 4;
  localparam int ALARM_W        = 5;
  localparam int SEG_W          = 7;
  localparam int KEY_W          = 4;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 4'd3;

  localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd10;
  localparam logic [KEY_W-1:0] KEY_START = 4'd11;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_COUNT = 3'b010,
    MODE_ALARM = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    RUN_IDLE  = 2'd0,
    RUN_COUNT = 2'd1,
    RUN_ALARM = 2'd2
  } run_mode_t;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_SHORT = 2'd1,
    BEEP_LONG  = 2'd2
  } beep_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg_thousands;
    logic [SEG_W-1:0] seg_hundreds;
    logic [SEG_W-1:0] seg_tens;
    logic [SEG_W-1:0] seg_units;
    run_mode_t        run_mode;
    beep_t            beep;
  } result_t;

  // Segment order gfedcba.
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] code;
    case (d)
      4'd0:    code = 7'h3f;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5b;
      4'd3:    code = 7'h4f;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6d;
      4'd6:    code = 7'h7d;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7f;
      4'd9:    code = 7'h6f;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  function automatic run_mode_t run_code(input mode_t m);
    run_mode_t r;
    case (m)
      MODE_COUNT: r = RUN_COUNT;
      MODE_ALARM: r = RUN_ALARM;
      default:    r = RUN_IDLE;
    endcase
    return r;
  endfunction

endpackage

@@ src/kct_step.sv @@
// Next-state and result logic for one request of the countdown timer.
module kct_step #(
  parameter int NUM_DIGITS = kct_pkg::NUM_DIGITS_DEF
) (
  input  logic [NUM_DIGITS-1:0][3:0]       digit_value,
  input  logic [NUM_DIGITS-1:0]            digit_shown,
  input  kct_pkg::mode_t                   mode,
  input  logic [kct_pkg::ALARM_W-1:0]      alarm_elapsed,
  input  logic [kct_pkg::HOLD_W-1:0]       hold_seconds,
  input  logic                             key_valid,
  input  logic [kct_pkg::KEY_W-1:0]        key_code,
  input  logic                             second_tick,
  output logic [NUM_DIGITS-1:0][3:0]       digit_value_next,
  output logic [NUM_DIGITS-1:0]            digit_shown_next,
  output kct_pkg::mode_t                   mode_next,
  output logic [kct_pkg::ALARM_W-1:0]      alarm_elapsed_next,
  output kct_pkg::result_t                 result
);

  localparam int UNITS = NUM_DIGITS - 1;

  logic [NUM_DIGITS-1:0][3:0] dec_value;
  logic [NUM_DIGITS-1:0]      dec_shown;
  logic [NUM_DIGITS-1:0]      tick_shown;
  logic [NUM_DIGITS-1:0][3:0] tick_value;
  logic [NUM_DIGITS-1:0]      tick_blank;
  kct_pkg::mode_t             tick_mode;
  logic [kct_pkg::ALARM_W-1:0] tick_alarm;
  logic [kct_pkg::ALARM_W-1:0] alarm_inc;
  kct_pkg::beep_t             beep_next;
  kct_pkg::beep_t             beep_out;
  logic [kct_pkg::SEG_W-1:0]  seg [4];

  // BCD decrement, borrow rippling from the units digit leftward.
  always_comb begin
    logic borrow;
    logic nz;
    borrow = 1'b1;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (borrow && digit_value[i] == 4'd0) begin
        dec_value[i] = 4'd9;
      end else if (borrow) begin
        dec_value[i] = digit_value[i] - 4'd1;
        borrow = 1'b0;
      end else begin
        dec_value[i] = digit_value[i];
      end
    end
    nz = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nz = nz | (dec_value[i] != 4'd0);
      dec_shown[i] = nz || (i == UNITS);
    end
  end

  assign alarm_inc = alarm_elapsed + kct_pkg::ALARM_W'(1);

  // Tick first.
  always_comb begin
    tick_value = digit_value;
    tick_shown = digit_shown;
    tick_mode  = mode;
    tick_alarm = alarm_elapsed;
    beep_next  = kct_pkg::BEEP_NONE;
    if (second_tick) begin
      case (mode)
        kct_pkg::MODE_COUNT: begin
          if (dec_value == '0) begin
            tick_value        = '0;
            tick_shown        = '0;
            tick_shown[UNITS] = 1'b1;
            tick_mode         = kct_pkg::MODE_ALARM;
            tick_alarm        = '0;
            beep_next         = kct_pkg::BEEP_LONG;
          end else begin
            tick_value = dec_value;
            tick_shown = dec_shown;
          end
        end
        kct_pkg::MODE_ALARM: begin
          if (alarm_inc > {1'b0, hold_seconds}) begin
            tick_value = '0;
            tick_shown = '0;
            tick_mode  = kct_pkg::MODE_IDLE;
            tick_alarm = '0;
          end else begin
            tick_alarm = alarm_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Leading-zero blanking of the digits after the tick, for a restart.
  always_comb begin
    logic nz;
    nz = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nz = nz | (tick_value[i] != 4'd0);
      tick_blank[i] = nz || (i == UNITS);
    end
  end

  // Then the key.
  always_comb begin
    digit_value_next   = tick_value;
    digit_shown_next   = tick_shown;
    mode_next          = tick_mode;
    alarm_elapsed_next = tick_alarm;
    beep_out           = beep_next;
    if (key_valid) begin
      case (key_code)
        kct_pkg::KEY_START: begin
          if (tick_value[UNITS] != 4'd0) begin
            digit_shown_next   = tick_blank;
            mode_next          = kct_pkg::MODE_COUNT;
            alarm_elapsed_next = '0;
            beep_out           = kct_pkg::BEEP_SHORT;
          end
        end
        kct_pkg::KEY_CLEAR: begin
          digit_value_next   = '0;
          digit_shown_next   = '0;
          mode_next          = kct_pkg::MODE_IDLE;
          alarm_elapsed_next = '0;
        end
        default: begin
          if ((key_code inside {[4'd0:4'd9]}) && tick_mode != kct_pkg::MODE_COUNT &&
              tick_mode != kct_pkg::MODE_ALARM) begin
            // Shift left only where the right neighbor is shown.
            for (int i = 0; i < NUM_DIGITS - 1; i++) begin
              if (tick_shown[i + 1]) begin
                digit_value_next[i] = tick_value[i + 1];
                digit_shown_next[i] = 1'b1;
              end
            end
            digit_value_next[UNITS] = key_code;
            digit_shown_next[UNITS] = 1'b1;
          end
        end
      endcase
    end
  end

  // Rightmost four positions drive the display.
  for (genvar g = 0; g < 4; g++) begin : g_seg
    if (NUM_DIGITS - 4 + g >= 0) begin : g_pos
      localparam int POS = NUM_DIGITS - 4 + g;
      assign seg[g] = digit_shown_next[POS] ? kct_pkg::seg_code(digit_value_next[POS])
                                             : kct_pkg::SEG_BLANK;
    end else begin : g_none
      assign seg[g] = kct_pkg::SEG_BLANK;
    end
  end

  assign result.seg_thousands = seg[0];
  assign result.seg_hundreds  = seg[1];
  assign result.seg_tens      = seg[2];
  assign result.seg_units     = seg[3];
  assign result.run_mode      = kct_pkg::run_code(mode_next);
  assign result.beep          = beep_out;

endmodule

@@ src/keypad_countdown_timer.sv @@
// Keypad countdown timer top level: state registers, result register and skid stage.
//
// Input channel (in_valid/in_stall): one request carries an optional key press
// (key_valid, key_code) and a one-second tick (second_tick). The tick is applied
// first, then the key. Output channel (out_valid/out_stall): exactly one result per
// request with four seven-segment codes (gfedcba, 0 = blank), run_mode and beep.
// An accepted request has its result registered in the result register, or in the
// skid register while the receiver stalls. Throughput is one request per cycle while
// in_stall is low; the digit update, BCD decrement and segment lookup all settle in
// the single step between the state registers and the result register.
// While the receiver stalls, the result register holds and one more result is
// parked in a skid register; in_stall rises only while that skid register is full.
// hold_seconds is written through cfg_write/cfg_data; write it only while idle (not enforced).
// Reset (rst, synchronous) blanks all digits, returns to idle, sets hold_seconds
// to 3 and drops both output entries.
module keypad_countdown_timer #(
  parameter int NUM_DIGITS = kct_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          key_valid,
  input  logic [kct_pkg::KEY_W-1:0]     key_code,
  input  logic                          second_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kct_pkg::SEG_W-1:0]     seg_thousands,
  output logic [kct_pkg::SEG_W-1:0]     seg_hundreds,
  output logic [kct_pkg::SEG_W-1:0]     seg_tens,
  output logic [kct_pkg::SEG_W-1:0]     seg_units,
  output logic [1:0]                    run_mode,
  output logic [1:0]                    beep,
  input  logic                          cfg_write,
  input  logic [kct_pkg::HOLD_W-1:0]    cfg_data
);

  logic [NUM_DIGITS-1:0][3:0]   digit_value;
  logic [NUM_DIGITS-1:0]        digit_shown;
  kct_pkg::mode_t               mode;
  logic [kct_pkg::ALARM_W-1:0]  alarm_elapsed;
  logic [kct_pkg::HOLD_W-1:0]   hold_seconds;

  logic [NUM_DIGITS-1:0][3:0]   digit_value_next;
  logic [NUM_DIGITS-1:0]        digit_shown_next;
  kct_pkg::mode_t               mode_next;
  logic [kct_pkg::ALARM_W-1:0]  alarm_elapsed_next;
  kct_pkg::result_t             step_result;

  kct_pkg::result_t             out_data;
  kct_pkg::result_t             skid_data;
  logic                         skid_valid;
  logic                         accept;
  logic                         out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  kct_step #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_step (
    .digit_value       (digit_value),
    .digit_shown       (digit_shown),
    .mode              (mode),
    .alarm_elapsed     (alarm_elapsed),
    .hold_seconds      (hold_seconds),
    .key_valid         (key_valid),
    .key_code          (key_code),
    .second_tick       (second_tick),
    .digit_value_next  (digit_value_next),
    .digit_shown_next  (digit_shown_next),
    .mode_next         (mode_next),
    .alarm_elapsed_next(alarm_elapsed_next),
    .result            (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_seconds <= kct_pkg::HOLD_RESET;
    end else if (cfg_write) begin
      hold_seconds <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_value   <= '0;
      digit_shown   <= '0;
      mode          <= kct_pkg::MODE_IDLE;
      alarm_elapsed <= '0;
    end else if (accept) begin
      digit_value   <= digit_value_next;
      digit_shown   <= digit_shown_next;
      mode          <= mode_next;
      alarm_elapsed <= alarm_elapsed_next;
    end
  end

  // Result register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : step_result;
    end
    if (accept && !out_free) begin
      skid_data <= step_result;
    end
  end

  assign seg_thousands = out_data.seg_thousands;
  assign seg_hundreds  = out_data.seg_hundreds;
  assign seg_tens      = out_data.seg_tens;
  assign seg_units     = out_data.seg_units;
  assign run_mode      = out_data.run_mode;
  assign beep          = out_data.beep;

endmodule

@@ src/kct_check.sv @@
// Port-level assertions for the keypad countdown timer, bound to the top level.
module kct_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [kct_pkg::SEG_W-1:0]     seg_thousands,
  input logic [kct_pkg::SEG_W-1:0]     seg_hundreds,
  input logic [kct_pkg::SEG_W-1:0]     seg_tens,
  input logic [kct_pkg::SEG_W-1:0]     seg_units,
  input logic [1:0]                    run_mode,
  input logic [1:0]                    beep
);

  a_reset_drops_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_start_beep_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep == kct_pkg::BEEP_SHORT |-> run_mode == kct_pkg::RUN_COUNT)
    else $error("start beep outside counting");

  // A clear in the same request as the last tick keeps the tone but blanks the display.
  a_alarm_beep_shows_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep == kct_pkg::BEEP_LONG |->
      seg_tens == kct_pkg::SEG_BLANK && seg_hundreds == kct_pkg::SEG_BLANK &&
      seg_thousands == kct_pkg::SEG_BLANK &&
      ((run_mode == kct_pkg::RUN_ALARM && seg_units == kct_pkg::seg_code(4'd0)) ||
       (run_mode == kct_pkg::RUN_IDLE && seg_units == kct_pkg::SEG_BLANK)))
    else $error("alarm tone without a lone zero on display");

  // Shown digits always form a run ending at the units place.
  a_blank_units_blanks_all: assert property (@(posedge clk) disable iff (rst)
    out_valid && seg_units == kct_pkg::SEG_BLANK |->
      seg_tens == kct_pkg::SEG_BLANK && seg_hundreds == kct_pkg::SEG_BLANK &&
      seg_thousands == kct_pkg::SEG_BLANK)
    else $error("digit shown left of a blank units place");

endmodule

bind keypad_countdown_timer kct_check u_kct_check (.*);
